// ===== sv/it3_pkg.sv =====
// Shared types and constants for the three-channel interval timer.
package it3_pkg;

    typedef enum logic [2:0] {
        OP_IO_WRITE  = 3'd0,
        OP_IO_READ   = 3'd1,
        OP_TICK      = 3'd2,
        OP_ADVANCE   = 3'd3,
        OP_SYS_WRITE = 3'd4,
        OP_SYS_READ  = 3'd5,
        OP_UNUSED6   = 3'd6,
        OP_UNUSED7   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAN,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

    localparam logic [15:0] DATA_BASE = 16'h0040;
    localparam logic [15:0] CMD_PORT  = 16'h0043;
    localparam logic [7:0]  SYS_MASK  = 8'h0F;
    localparam int unsigned NUM_CHAN  = 3;
    localparam int unsigned DIV_BITS  = 32;

endpackage

// ===== sv/interval_timer_three_channel.sv =====
// Top level of the three-channel interval timer with a shared serial divider.
//
// Usage: one input channel (operation, port, write_byte, tick_count) and one
// result channel (read_byte, status, wrap_count), both valid/stall. Every
// accepted item gives exactly one result.
// Io and port 0x61 operations and a tick do their work in ST_CHAN, and
// the result is then valid in ST_OUT. An advance walks the three channels
// in turn; a periodic channel runs a restoring divide of tick_count by its
// 17-bit period in ST_DIV, one quotient bit a cycle, and folds the result
// into its count in ST_FINISH, while a one-shot channel settles in ST_CHAN.
// The shared divider and the channel walk set how long an advance takes.
// One item is in work at a time: in_stall is high from acceptance until the
// result has been transferred, and the next item can be taken in the cycle
// after that. The result register holds while out_stall is high, and no new
// item is taken meanwhile.
// Reset clears all channel state to zero with byte access lo-then-hi, and
// clears port 0x61 bits, the refresh toggle and channel 2 OUT.
module interval_timer_three_channel
    import it3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [15:0] port,
    input  logic [7:0]  write_byte,
    input  logic [31:0] tick_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_byte,
    output logic        status,
    output logic [31:0] wrap_count
);

    state_t state_reg, state_next;

    logic [15:0] reload_reg   [NUM_CHAN];
    logic [15:0] count_reg    [NUM_CHAN];
    logic [2:0]  mode_reg     [NUM_CHAN];
    logic [1:0]  access_reg   [NUM_CHAN];
    logic        bcd_reg      [NUM_CHAN];
    logic        wphase_reg   [NUM_CHAN];
    logic [15:0] snap_reg     [NUM_CHAN];
    logic        held_reg     [NUM_CHAN];
    logic        rphase_reg   [NUM_CHAN];
    logic [7:0]  sys_reg;
    logic        spk_reg;
    logic        refresh_reg;

    logic [2:0]  op_reg;
    logic [15:0] port_reg;
    logic [7:0]  wb_reg;
    logic [31:0] ticks_reg;

    logic [1:0]  chan_reg;
    logic [5:0]  bit_reg;
    logic [31:0] quot_reg;
    logic [16:0] rem_reg;
    logic [31:0] dvd_reg;

    logic [7:0]  rb_reg;
    logic        st_reg;
    logic [31:0] wrap_reg;

    logic in_fire, out_fire;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // Channel under advance and its derived period
    logic [16:0] period;
    logic [16:0] cur;
    logic        periodic;
    logic [17:0] trial;
    assign periodic = (mode_reg[chan_reg] == 3'd2) || (mode_reg[chan_reg] == 3'd3);
    assign period   = (reload_reg[chan_reg] == 16'd0) ? 17'h10000
                                                      : {1'b0, reload_reg[chan_reg]};
    assign cur      = (count_reg[chan_reg] == 16'd0) ? period
                                                     : {1'b0, count_reg[chan_reg]};
    assign trial    = {rem_reg, dvd_reg[31]} - {1'b0, period};

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_CHAN;
            end
            ST_CHAN:
            begin
                if (op_reg != OP_ADVANCE || ticks_reg == 32'd0)
                    state_next = ST_OUT;
                else if (periodic)
                    state_next = ST_DIV;
                else if (chan_reg == 2'd2)
                    state_next = ST_OUT;
            end
            ST_DIV:
            begin
                if (bit_reg == 6'd31)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (chan_reg == 2'd2)
                    state_next = ST_OUT;
                else
                    state_next = ST_CHAN;
            end
            ST_OUT:
            begin
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
    end

    assign read_byte  = rb_reg;
    assign status     = st_reg;
    assign wrap_count = wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= operation;
            port_reg  <= port;
            wb_reg    <= write_byte;
            ticks_reg <= tick_count;
        end
    end

    // Decode of the captured port
    logic        is_data;
    logic [1:0]  dchan;
    logic [15:0] poff;
    assign is_data = (port_reg >= DATA_BASE) && (port_reg < CMD_PORT);
    assign poff    = port_reg - DATA_BASE;
    assign dchan   = poff[1:0];

    logic [1:0] csel, cacc;
    assign csel = wb_reg[7:6];
    assign cacc = wb_reg[5:4];

    logic [15:0] rdv;
    assign rdv = held_reg[dchan] ? snap_reg[dchan] : count_reg[dchan];

    // Timer state, divider and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                reload_reg[c] <= '0;
                count_reg[c]  <= '0;
                mode_reg[c]   <= '0;
                access_reg[c] <= 2'd3;
                bcd_reg[c]    <= 1'b0;
                wphase_reg[c] <= 1'b0;
                snap_reg[c]   <= '0;
                held_reg[c]   <= 1'b0;
                rphase_reg[c] <= 1'b0;
            end
            sys_reg     <= '0;
            spk_reg     <= 1'b0;
            refresh_reg <= 1'b0;
            chan_reg    <= '0;
            bit_reg     <= '0;
            quot_reg    <= '0;
            rem_reg     <= '0;
            dvd_reg     <= '0;
            rb_reg      <= '0;
            st_reg      <= 1'b0;
            wrap_reg    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                chan_reg <= '0;
                rb_reg   <= '0;
                st_reg   <= 1'b0;
                wrap_reg <= '0;
            end
            if (state_reg == ST_CHAN && op_reg != OP_ADVANCE)
            begin
                // Single-step operations
                case (op_reg)
                    OP_IO_WRITE:
                    begin
                        if (is_data)
                        begin
                            case (access_reg[dchan])
                                2'd1:
                                begin
                                    reload_reg[dchan] <= {reload_reg[dchan][15:8], wb_reg};
                                    count_reg[dchan]  <= {reload_reg[dchan][15:8], wb_reg};
                                end
                                2'd2:
                                begin
                                    reload_reg[dchan] <= {wb_reg, reload_reg[dchan][7:0]};
                                    count_reg[dchan]  <= {wb_reg, reload_reg[dchan][7:0]};
                                end
                                2'd3:
                                begin
                                    if (!wphase_reg[dchan])
                                    begin
                                        reload_reg[dchan] <= {reload_reg[dchan][15:8], wb_reg};
                                        wphase_reg[dchan] <= 1'b1;
                                    end
                                    else
                                    begin
                                        reload_reg[dchan] <= {wb_reg, reload_reg[dchan][7:0]};
                                        count_reg[dchan]  <= {wb_reg, reload_reg[dchan][7:0]};
                                        wphase_reg[dchan] <= 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        else if (port_reg == CMD_PORT)
                        begin
                            if (csel != 2'd3)
                            begin
                                if (cacc == 2'd0)
                                begin
                                    snap_reg[csel]   <= count_reg[csel];
                                    held_reg[csel]   <= 1'b1;
                                    rphase_reg[csel] <= 1'b0;
                                end
                                else
                                begin
                                    access_reg[csel] <= cacc;
                                    mode_reg[csel]   <= wb_reg[3:1];
                                    bcd_reg[csel]    <= wb_reg[0];
                                    wphase_reg[csel] <= 1'b0;
                                    if (csel == 2'd2)
                                        spk_reg <= 1'b0;
                                end
                            end
                        end
                        else
                            st_reg <= 1'b1;
                    end
                    OP_IO_READ:
                    begin
                        if (is_data)
                        begin
                            case (access_reg[dchan])
                                2'd1:
                                begin
                                    held_reg[dchan] <= 1'b0;
                                    rb_reg <= rdv[7:0];
                                end
                                2'd2:
                                begin
                                    held_reg[dchan] <= 1'b0;
                                    rb_reg <= rdv[15:8];
                                end
                                2'd3:
                                begin
                                    if (!rphase_reg[dchan])
                                    begin
                                        rphase_reg[dchan] <= 1'b1;
                                        rb_reg <= rdv[7:0];
                                    end
                                    else
                                    begin
                                        rphase_reg[dchan] <= 1'b0;
                                        held_reg[dchan]   <= 1'b0;
                                        rb_reg <= rdv[15:8];
                                    end
                                end
                                default: rb_reg <= '0;
                            endcase
                        end
                        else
                            st_reg <= 1'b1;
                    end
                    OP_TICK:
                    begin
                        for (int c = 0; c < NUM_CHAN; c++)
                        begin
                            if (count_reg[c] == 16'd0)
                            begin
                                if (mode_reg[c] == 3'd2 || mode_reg[c] == 3'd3)
                                    count_reg[c] <= reload_reg[c];
                            end
                            else
                            begin
                                count_reg[c] <= count_reg[c] - 16'd1;
                                if (c == 2 && count_reg[c] == 16'd1 && mode_reg[c] == 3'd0)
                                    spk_reg <= 1'b1;
                            end
                        end
                    end
                    OP_SYS_WRITE:
                        sys_reg <= wb_reg & SYS_MASK;
                    OP_SYS_READ:
                    begin
                        refresh_reg <= !refresh_reg;
                        rb_reg <= {2'b00, spk_reg, !refresh_reg, sys_reg[3:0]};
                    end
                    default: ;
                endcase
            end
            else if (state_reg == ST_CHAN && ticks_reg != 32'd0)
            begin
                // Advance: one-shot channels settle now, periodic ones divide
                if (periodic)
                begin
                    bit_reg  <= '0;
                    quot_reg <= '0;
                    rem_reg  <= '0;
                    dvd_reg  <= ticks_reg;
                end
                else
                begin
                    if ({16'd0, count_reg[chan_reg]} <= ticks_reg)
                    begin
                        count_reg[chan_reg] <= '0;
                        if (chan_reg == 2'd2 && mode_reg[chan_reg] == 3'd0)
                            spk_reg <= 1'b1;
                    end
                    else
                        count_reg[chan_reg] <= count_reg[chan_reg] - ticks_reg[15:0];
                    chan_reg <= chan_reg + 2'd1;
                end
            end
            else if (state_reg == ST_DIV)
            begin
                // One restoring quotient bit per cycle
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                bit_reg <= bit_reg + 6'd1;
                if (!trial[17])
                begin
                    rem_reg  <= trial[16:0];
                    quot_reg <= {quot_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= {rem_reg[15:0], dvd_reg[31]};
                    quot_reg <= {quot_reg[30:0], 1'b0};
                end
            end
            else if (state_reg == ST_FINISH)
            begin
                // Fold remainder into the count; channel 0 wraps from quotient
                if (rem_reg < cur)
                    count_reg[chan_reg] <= 16'(cur - rem_reg);
                else
                    count_reg[chan_reg] <= 16'(period - (rem_reg - cur));
                if (chan_reg == 2'd0 && {15'd0, cur} <= ticks_reg)
                    wrap_reg <= quot_reg + ((rem_reg >= cur) ? 32'd1 : 32'd0);
                chan_reg <= chan_reg + 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    // A result appears only after an item has been taken
    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) != ST_IDLE)
        else $error("result without item");
    // No item is taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted with result pending");
    // Errors only for io operations
    a_status_io: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (op_reg == OP_IO_WRITE || op_reg == OP_IO_READ))
        else $error("status on non-io operation");
    // Wraps only reported by advance
    a_wrap_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wrap_count != 32'd0) |-> op_reg == OP_ADVANCE)
        else $error("wrap count outside advance");
`endif

endmodule

// ===== tb/interval_timer_three_channel_tb.sv =====
// Self-checking testbench for the three-channel interval timer.
`timescale 1ns / 1ps

module interval_timer_three_channel_tb;
    import it3_pkg::*;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] port;
        logic [7:0]  write_byte;
        logic [31:0] tick_count;
    } timer_op_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        status;
        logic [31:0] wrap_count;
    } timer_res_t;

    localparam int LIMIT_CYCLES = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  operation;
    logic [15:0] port;
    logic [7:0]  write_byte;
    logic [31:0] tick_count;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_byte;
    logic        status;
    logic [31:0] wrap_count;

    interval_timer_three_channel dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .port       (port),
        .write_byte (write_byte),
        .tick_count (tick_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_byte  (read_byte),
        .status     (status),
        .wrap_count (wrap_count)
    );

    // Timer state as seen by the predictor
    logic [15:0] reload_q [3];
    logic [15:0] count_q [3];
    logic [2:0]  mode_q [3];
    logic [1:0]  access_q [3];
    logic        wr_hi_q [3];
    logic [15:0] latch_q [3];
    logic        latched_q [3];
    logic        rd_hi_q [3];
    logic [7:0]  sys_bits_q;
    logic        out2_q;
    logic        refresh_q;

    timer_op_t  pending_ops [$];
    timer_res_t expected_res [$];
    int         errors;
    int         cycles;
    bit         stim_done;
    bit         hold_for_drain;
    int         in_gap;
    int         out_gap;

    // Stall as sampled at the last rising edge
    logic in_stall_s;

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit periodic(int c);
        return mode_q[c] == 3'd2 || mode_q[c] == 3'd3;
    endfunction

    // Work out the result of one operation and update the timer state
    function automatic timer_res_t timer_predict(timer_op_t op);
        timer_res_t  res;
        int          c;
        logic [15:0] v;
        logic [1:0]  sel;
        logic [1:0]  acc;
        logic [32:0] period;
        logic [32:0] cur;
        logic [32:0] stp;
        logic [32:0] tk;
        res = '0;
        case (op_t'(op.operation))
            OP_IO_WRITE:
            begin
                if (op.port >= DATA_BASE && op.port < CMD_PORT)
                begin
                    c = op.port - DATA_BASE;
                    case (access_q[c])
                        2'd1:
                        begin
                            reload_q[c][7:0] = op.write_byte;
                            count_q[c] = reload_q[c];
                        end
                        2'd2:
                        begin
                            reload_q[c][15:8] = op.write_byte;
                            count_q[c] = reload_q[c];
                        end
                        2'd3:
                        begin
                            if (!wr_hi_q[c])
                                reload_q[c][7:0] = op.write_byte;
                            else
                            begin
                                reload_q[c][15:8] = op.write_byte;
                                count_q[c] = reload_q[c];
                            end
                            wr_hi_q[c] = ~wr_hi_q[c];
                        end
                        default: ;
                    endcase
                end
                else if (op.port == CMD_PORT)
                begin
                    sel = op.write_byte[7:6];
                    acc = op.write_byte[5:4];
                    if (sel != 2'd3)
                    begin
                        if (acc == 2'd0)
                        begin
                            latch_q[sel] = count_q[sel];
                            latched_q[sel] = 1'b1;
                            rd_hi_q[sel] = 1'b0;
                        end
                        else
                        begin
                            access_q[sel] = acc;
                            mode_q[sel] = op.write_byte[3:1];
                            wr_hi_q[sel] = 1'b0;
                            if (sel == 2'd2)
                                out2_q = 1'b0;
                        end
                    end
                end
                else
                    res.status = 1'b1;
            end
            OP_IO_READ:
            begin
                if (op.port >= DATA_BASE && op.port < CMD_PORT)
                begin
                    c = op.port - DATA_BASE;
                    v = latched_q[c] ? latch_q[c] : count_q[c];
                    case (access_q[c])
                        2'd1:
                        begin
                            latched_q[c] = 1'b0;
                            res.read_byte = v[7:0];
                        end
                        2'd2:
                        begin
                            latched_q[c] = 1'b0;
                            res.read_byte = v[15:8];
                        end
                        2'd3:
                        begin
                            res.read_byte = rd_hi_q[c] ? v[15:8] : v[7:0];
                            if (rd_hi_q[c])
                                latched_q[c] = 1'b0;
                            rd_hi_q[c] = ~rd_hi_q[c];
                        end
                        default: ;
                    endcase
                end
                else
                    res.status = 1'b1;
            end
            OP_TICK:
            begin
                for (c = 0; c < 3; c++)
                begin
                    if (count_q[c] == 16'd0)
                    begin
                        if (periodic(c))
                            count_q[c] = reload_q[c];
                    end
                    else
                    begin
                        count_q[c] = count_q[c] - 16'd1;
                        if (c == 2 && count_q[c] == 16'd0 && mode_q[c] == 3'd0)
                            out2_q = 1'b1;
                    end
                end
            end
            OP_ADVANCE:
            begin
                tk = {1'b0, op.tick_count};
                if (tk != 0)
                begin
                    for (c = 0; c < 3; c++)
                    begin
                        if (periodic(c))
                        begin
                            period = reload_q[c] != 0 ? {17'd0, reload_q[c]} : 33'h10000;
                            cur = count_q[c] != 0 ? {17'd0, count_q[c]} : period;
                            stp = tk % period;
                            if (c == 0 && tk >= cur)
                                res.wrap_count = 32'(1 + (tk - cur) / period);
                            cur = (stp < cur) ? cur - stp : period - (stp - cur);
                            count_q[c] = cur[15:0];
                        end
                        else if (tk >= {17'd0, count_q[c]})
                        begin
                            count_q[c] = 16'd0;
                            if (c == 2 && mode_q[c] == 3'd0)
                                out2_q = 1'b1;
                        end
                        else
                            count_q[c] = count_q[c] - tk[15:0];
                    end
                end
            end
            OP_SYS_WRITE:
                sys_bits_q = op.write_byte & SYS_MASK;
            OP_SYS_READ:
            begin
                refresh_q = ~refresh_q;
                res.read_byte = {2'b00, out2_q, refresh_q, sys_bits_q[3:0]};
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic timer_op_t make_op(op_t o, logic [15:0] p, logic [7:0] b,
                                          logic [31:0] t);
        timer_op_t op;
        op.operation = o;
        op.port = p;
        op.write_byte = b;
        op.tick_count = t;
        return op;
    endfunction

    function automatic logic [31:0] rand_ticks();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 20);
            1: return $urandom_range(0, 300000);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_port();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return DATA_BASE + 16'($urandom_range(0, 3));
    endfunction

    // Random item, mostly io writes and reads with random content
    function automatic timer_op_t rand_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 15)
            return make_op(OP_IO_WRITE, CMD_PORT, 8'($urandom), $urandom);
        else if (k < 40)
            return make_op(OP_IO_WRITE, rand_port(), 8'($urandom), $urandom);
        else if (k < 60)
            return make_op(OP_IO_READ, rand_port(), 8'($urandom), $urandom);
        else if (k < 72)
            return make_op(OP_TICK, 16'($urandom), 8'($urandom), $urandom);
        else if (k < 87)
            return make_op(OP_ADVANCE, 16'($urandom), 8'($urandom), rand_ticks());
        else if (k < 92)
            return make_op(OP_SYS_WRITE, 16'($urandom), 8'($urandom), $urandom);
        else if (k < 98)
            return make_op(OP_SYS_READ, 16'($urandom), 8'($urandom), $urandom);
        return make_op(op_t'($urandom_range(6, 7)), 16'($urandom), 8'($urandom),
                       $urandom);
    endfunction

    // Drive one transfer per accepted item, with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // Hold a waiting transfer; otherwise pick the next gap or item
            if (!(in_valid && in_stall_s))
            begin
                if (in_valid)
                    in_gap = gap_len();
                else if (in_gap > 0)
                    in_gap = in_gap - 1;
                if (pending_ops.size() > 0 && in_gap == 0 && !hold_for_drain)
                begin
                    in_valid <= 1'b1;
                    {operation, port, write_byte, tick_count} <= pending_ops.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= (out_gap > 0);
            out_gap <= (out_gap > 0) ? out_gap - 1 :
                       ($urandom_range(0, 3) == 0 ? gap_len() : 0);
        end
    end

    // Predict on input transfers and check output transfers
    always @(posedge clk)
    begin
        timer_res_t got;
        timer_res_t want;
        in_stall_s <= in_stall;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (in_valid && !in_stall)
                expected_res.push_back(timer_predict({operation, port, write_byte,
                                                      tick_count}));
            if (out_valid && !out_stall)
            begin
                got = {read_byte, status, wrap_count};
                if (expected_res.size() == 0)
                begin
                    $display("%0t: result with none expected: rb=%h st=%0d wrap=%0d",
                             $time, read_byte, status, wrap_count);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_res.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected rb=%h st=%0d wrap=%0d, actual rb=%h st=%0d wrap=%0d",
                                 $time, want.read_byte, want.status, want.wrap_count,
                                 read_byte, status, wrap_count);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    // Fill the item queue, release reset and drain between the two halves
    initial
    begin
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        operation = '0;
        port = '0;
        write_byte = '0;
        tick_count = '0;
        errors = 0;
        cycles = 0;
        in_gap = 0;
        out_gap = 0;
        hold_for_drain = 0;
        in_stall_s = 1'b1;
        for (i = 0; i < 3; i++)
        begin
            reload_q[i] = '0;
            count_q[i] = '0;
            mode_q[i] = '0;
            access_q[i] = 2'd3;
            wr_hi_q[i] = 1'b0;
            latch_q[i] = '0;
            latched_q[i] = 1'b0;
            rd_hi_q[i] = 1'b0;
        end
        sys_bits_q = '0;
        out2_q = 1'b0;
        refresh_q = 1'b0;

        // Directed: reset reads, loads, latch, modes, wraps, port 0x61
        pending_ops.push_back(make_op(OP_IO_READ, 16'h0040, 8'h00, 0));
        pending_ops.push_back(make_op(OP_IO_WRITE, 16'h0040, 8'hFF, 0));
        pending_ops.push_back(make_op(OP_IO_WRITE, 16'h0040, 8'h00, 0));
        pending_ops.push_back(make_op(OP_ADVANCE, 16'h0, 8'h0, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(OP_IO_WRITE, CMD_PORT, 8'h34, 0));
        pending_ops.push_back(make_op(OP_IO_WRITE, 16'h0040, 8'h03, 0));
        pending_ops.push_back(make_op(OP_IO_WRITE, 16'h0040, 8'h00, 0));
        pending_ops.push_back(make_op(OP_ADVANCE, 16'h0, 8'h0, 32'd10));
        pending_ops.push_back(make_op(OP_ADVANCE, 16'h0, 8'h0, 32'd0));
        pending_ops.push_back(make_op(OP_IO_WRITE, CMD_PORT, 8'h00, 0));
        pending_ops.push_back(make_op(OP_TICK, 16'h0, 8'h0, 0));
        pending_ops.push_back(make_op(OP_IO_READ, 16'h0040, 8'h0, 0));
        pending_ops.push_back(make_op(OP_IO_READ, 16'h0040, 8'h0, 0));
        pending_ops.push_back(make_op(OP_IO_WRITE, CMD_PORT, 8'h90, 0));
        pending_ops.push_back(make_op(OP_IO_WRITE, 16'h0042, 8'h02, 0));
        pending_ops.push_back(make_op(OP_TICK, 16'h0, 8'h0, 0));
        pending_ops.push_back(make_op(OP_TICK, 16'h0, 8'h0, 0));
        pending_ops.push_back(make_op(OP_IO_WRITE, CMD_PORT, 8'hEE, 0));
        pending_ops.push_back(make_op(OP_IO_WRITE, 16'hFFFF, 8'hAA, 0));
        pending_ops.push_back(make_op(OP_IO_READ, CMD_PORT, 8'h0, 0));
        pending_ops.push_back(make_op(OP_SYS_WRITE, 16'h0, 8'hFF, 0));
        pending_ops.push_back(make_op(OP_SYS_READ, 16'h0, 8'h0, 0));
        pending_ops.push_back(make_op(OP_SYS_READ, 16'h0, 8'h0, 0));
        pending_ops.push_back(make_op(OP_UNUSED6, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(OP_UNUSED7, 16'h0, 8'h0, 0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Random items in two halves, draining between them
        for (i = 0; i < 200; i++)
            pending_ops.push_back(rand_op());
        wait (pending_ops.size() == 0 || cycles > LIMIT_CYCLES);
        @(posedge clk);
        hold_for_drain = 1;
        while (!((expected_res.size() == 0 && !in_valid) || cycles > LIMIT_CYCLES))
            @(posedge clk);
        hold_for_drain = 0;
        for (i = 0; i < 200; i++)
            pending_ops.push_back(rand_op());
        stim_done = 1;
    end

    // End of run or timeout
    initial
    begin
        wait (stim_done || cycles > LIMIT_CYCLES);
        @(posedge clk);
        while (!((pending_ops.size() == 0 && !in_valid && expected_res.size() == 0)
                 || cycles > LIMIT_CYCLES))
            @(posedge clk);
        if (cycles > LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            repeat (200) @(posedge clk);
            if (errors == 0 && expected_res.size() == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

// ===== files.f =====
sv/it3_pkg.sv
sv/interval_timer_three_channel.sv
tb/interval_timer_three_channel_tb.sv
